FILE: rtl/remote_frame_builder_crc16_defines.svh
// Assertion macros for the remote frame builder.
`ifndef REMOTE_FRAME_BUILDER_CRC16_DEFINES_SVH
`define REMOTE_FRAME_BUILDER_CRC16_DEFINES_SVH

`ifndef SYNTH
`define RFB_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rfb assertion failed");
`define RFB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfb assertion failed");
`define RFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfb assertion failed");
`else
`define RFB_ASSERT(lbl, clk, rst_n, cond)
`define RFB_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/rfb_pkg.sv
package rfb_pkg;

    localparam logic [7:0]  SYNC0     = 8'hAA;
    localparam logic [7:0]  SYNC_JOY  = 8'h55;
    localparam logic [7:0]  SYNC_MODE = 8'h56;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_TOP   = 16'h8000;

    localparam logic KIND_JOY  = 1'b0;
    localparam logic KIND_MODE = 1'b1;

    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] JOY_LAST  = POS_W'(11);
    localparam logic [POS_W-1:0] MODE_LAST = POS_W'(5);

    typedef struct packed {
        logic        kind;
        logic [15:0] axis_x;
        logic [15:0] axis_y;
        logic [15:0] axis_z;
        logic [7:0]  mode_flags;
        logic [7:0]  seq;
    } frame_t;

    typedef struct packed {
        logic done;
    } emit_status_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((acc & CRC_TOP) != 16'h0000)
                acc = {acc[14:0], 1'b0} ^ CRC_POLY;
            else
                acc = {acc[14:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

FILE: rtl/remote_frame_builder_crc16.sv
// Channel   Direction  Handshake            Payload
// request   in         in_valid/in_stall    kind, axis_x, axis_y, axis_z, mode_flags
// frame     out        out_valid/out_stall  frame_byte, end_of_frame
//
// One byte per cycle while the output is not stalled: a joystick frame has 12 bytes, a mode frame 6.
// A request is held in a one-entry frame slot; the next one is taken on the
// cycle the last byte of the current frame enters the output register.
// CRC is updated one byte per cycle, while the output is not stalled, by the byte-wide CRC step.
// Reset clears the sequence counters, the slot valid flag, the byte position and the output valid flag.
// out_stall, while the output register is valid, holds it and pauses the byte counter.

module remote_frame_builder_crc16
    import rfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] axis_x,
    input  logic [15:0] axis_y,
    input  logic [15:0] axis_z,
    input  logic [7:0]  mode_flags,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        end_of_frame
);

    emit_status_t status;
    logic         slot_valid;
    frame_t       slot;

    rfb_capture u_capture
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z),
        .mode_flags (mode_flags),
        .status     (status),
        .slot_valid (slot_valid),
        .slot       (slot)
    );

    rfb_emitter u_emitter
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot_valid   (slot_valid),
        .slot         (slot),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame)
    );

endmodule

FILE: rtl/rfb_capture.sv
module rfb_capture
    import rfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         kind,
    input  logic [15:0]  axis_x,
    input  logic [15:0]  axis_y,
    input  logic [15:0]  axis_z,
    input  logic [7:0]   mode_flags,
    input  emit_status_t status,
    output logic         slot_valid,
    output frame_t       slot
);

    logic   slot_valid_reg;
    logic   slot_valid_next;
    frame_t slot_reg;
    logic [7:0] joy_seq_reg;
    logic [7:0] mode_seq_reg;
    logic   accept;

    assign in_stall = slot_valid_reg && !status.done;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (accept)
            slot_valid_next = 1'b1;
        else if (status.done)
            slot_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            joy_seq_reg    <= 8'h00;
            mode_seq_reg   <= 8'h00;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            if (accept)
            begin
                if (kind == KIND_MODE)
                    mode_seq_reg <= mode_seq_reg + 8'd1;
                else
                    joy_seq_reg <= joy_seq_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg.kind       <= kind;
            slot_reg.axis_x     <= axis_x;
            slot_reg.axis_y     <= axis_y;
            slot_reg.axis_z     <= axis_z;
            slot_reg.mode_flags <= mode_flags;
            slot_reg.seq        <= (kind == KIND_MODE) ? mode_seq_reg : joy_seq_reg;
        end
    end

    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;

endmodule

FILE: rtl/rfb_emitter.sv
`include "remote_frame_builder_crc16_defines.svh"

module rfb_emitter
    import rfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         slot_valid,
    input  frame_t       slot,
    output emit_status_t status,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   frame_byte,
    output logic         end_of_frame
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_eof_reg;
    logic             advance;
    logic             last;
    logic [POS_W-1:0] last_pos;
    logic [7:0]       cur_byte;

    assign advance  = slot_valid && (!out_valid_reg || !out_stall);
    assign last_pos = (slot.kind == KIND_MODE) ? MODE_LAST : JOY_LAST;
    assign last     = (pos_reg == last_pos);

    always_comb
    begin
        cur_byte = 8'h00;
        if (slot.kind == KIND_MODE)
        begin
            case (pos_reg)
                4'd0:    cur_byte = SYNC0;
                4'd1:    cur_byte = SYNC_MODE;
                4'd2:    cur_byte = slot.seq;
                4'd3:    cur_byte = slot.mode_flags;
                4'd4:    cur_byte = crc_reg[7:0];
                4'd5:    cur_byte = crc_reg[15:8];
                default: cur_byte = 8'h00;
            endcase
        end
        else
        begin
            case (pos_reg)
                4'd0:    cur_byte = SYNC0;
                4'd1:    cur_byte = SYNC_JOY;
                4'd2:    cur_byte = slot.seq;
                4'd3:    cur_byte = slot.axis_x[7:0];
                4'd4:    cur_byte = slot.axis_x[15:8];
                4'd5:    cur_byte = slot.axis_y[7:0];
                4'd6:    cur_byte = slot.axis_y[15:8];
                4'd7:    cur_byte = slot.axis_z[7:0];
                4'd8:    cur_byte = slot.axis_z[15:8];
                4'd9:    cur_byte = 8'h00;
                4'd10:   cur_byte = crc_reg[7:0];
                4'd11:   cur_byte = crc_reg[15:8];
                default: cur_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (advance)
        begin
            pos_next = last ? '0 : pos_reg + POS_W'(1);
            if (pos_reg == '0)
                crc_next = crc16_byte(CRC_INIT, cur_byte);
            else if (pos_reg < last_pos - POS_W'(1))
                crc_next = crc16_byte(crc_reg, cur_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_eof_reg  <= last;
        end
    end

    assign status.done  = advance && last;
    assign out_valid    = out_valid_reg;
    assign frame_byte   = out_byte_reg;
    assign end_of_frame = out_eof_reg;

    `RFB_ASSERT_SAME(a_pos_idle, clk, rst_n, pos_reg != '0, slot_valid)
    `RFB_ASSERT_SAME(a_pos_range, clk, rst_n, slot_valid, pos_reg <= last_pos)
    `RFB_ASSERT_NEXT(a_eof_last, clk, rst_n, advance && last, out_valid_reg && out_eof_reg)
    `RFB_ASSERT_NEXT(a_restart, clk, rst_n, advance && last, pos_reg == '0)

endmodule

FILE: tb/tb_remote_frame_builder_crc16.sv
`timescale 1ns / 100ps

module tb_remote_frame_builder_crc16;
    import rfb_pkg::*;

    typedef struct {
        logic        kind;
        logic [15:0] axis_x;
        logic [15:0] axis_y;
        logic [15:0] axis_z;
        logic [7:0]  mode_flags;
    } frame_request_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_octet_t;

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_RECEIVER_STALLS,
        TRAFFIC_BOTH
    } traffic_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = KIND_JOY;
    logic [15:0] axis_x = '0;
    logic [15:0] axis_y = '0;
    logic [15:0] axis_z = '0;
    logic [7:0]  mode_flags = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        end_of_frame;

    frame_request_t pending_requests[$];
    frame_octet_t   octets_due[$];
    frame_request_t next_request;
    frame_octet_t   due_octet;
    traffic_t       traffic = TRAFFIC_STEADY;
    logic           request_taken = 1'b0;
    logic [7:0]     joystick_seq = '0;
    logic [7:0]     mode_seq = '0;
    int             error_count = 0;

    remote_frame_builder_crc16 dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .axis_x(axis_x),
        .axis_y(axis_y),
        .axis_z(axis_z),
        .mode_flags(mode_flags),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .frame_byte(frame_byte),
        .end_of_frame(end_of_frame)
    );

    always #4 clk = ~clk;

    function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] acc;
        logic        feedback;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = acc[15] ^ data[i];
            acc = {acc[14:0], 1'b0};
            if (feedback)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    // Builds the expected frame and advances the sequence counter of its kind.
    task automatic queue_frame(input frame_request_t req);
        logic [7:0]   octets[12];
        logic [15:0]  crc;
        int           len;
        frame_octet_t o;
        octets[0] = SYNC0;
        if (req.kind == KIND_JOY)
        begin
            octets[1] = SYNC_JOY;
            octets[2] = joystick_seq;
            octets[3] = req.axis_x[7:0];
            octets[4] = req.axis_x[15:8];
            octets[5] = req.axis_y[7:0];
            octets[6] = req.axis_y[15:8];
            octets[7] = req.axis_z[7:0];
            octets[8] = req.axis_z[15:8];
            octets[9] = 8'h00;
            joystick_seq = joystick_seq + 8'd1;
            len = 12;
        end
        else
        begin
            octets[1] = SYNC_MODE;
            octets[2] = mode_seq;
            octets[3] = req.mode_flags;
            mode_seq = mode_seq + 8'd1;
            len = 6;
        end
        crc = CRC_INIT;
        for (int k = 0; k < len - 2; k++)
            crc = crc_ccitt_next(crc, octets[k]);
        octets[len - 2] = crc[7:0];
        octets[len - 1] = crc[15:8];
        for (int k = 0; k < len; k++)
        begin
            o.data = octets[k];
            o.last = (k == len - 1);
            octets_due.push_back(o);
        end
    endtask

    task automatic add_request(input logic k, input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input logic [7:0] flags);
        frame_request_t req;
        req.kind = k;
        req.axis_x = x;
        req.axis_y = y;
        req.axis_z = z;
        req.mode_flags = flags;
        pending_requests.push_back(req);
    endtask

    function automatic logic [15:0] pick_axis();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic sender_gap();
        case (traffic)
            TRAFFIC_SENDER_GAPS: return $urandom_range(99) < 83;
            TRAFFIC_BOTH: return $urandom_range(99) < 22;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stall();
        case (traffic)
            TRAFFIC_RECEIVER_STALLS: return $urandom_range(99) < 83;
            TRAFFIC_BOTH: return $urandom_range(99) < 22;
            default: return 1'b0;
        endcase
    endfunction

    // Request driver: a payload only changes once its transaction has gone through.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || request_taken))
        begin
            if (pending_requests.size() != 0 && !sender_gap())
            begin
                next_request = pending_requests.pop_front();
                in_valid <= 1'b1;
                kind <= next_request.kind;
                axis_x <= next_request.axis_x;
                axis_y <= next_request.axis_y;
                axis_z <= next_request.axis_z;
                mode_flags <= next_request.mode_flags;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= receiver_stall();
    end

    // Accepted requests are predicted before the output side is checked.
    always @(posedge clk)
    begin
        request_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            queue_frame('{kind, axis_x, axis_y, axis_z, mode_flags});
        if (rst_n && out_valid && !out_stall)
        begin
            if (octets_due.size() == 0)
            begin
                $error("unexpected transaction: frame_byte %02h end_of_frame %0b",
                       frame_byte, end_of_frame);
                error_count++;
            end
            else
            begin
                due_octet = octets_due.pop_front();
                if (frame_byte !== due_octet.data)
                begin
                    $error("frame_byte: expected %02h, actual %02h", due_octet.data, frame_byte);
                    error_count++;
                end
                if (end_of_frame !== due_octet.last)
                begin
                    $error("end_of_frame: expected %0b, actual %0b",
                           due_octet.last, end_of_frame);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int   joystick_left;
        int   mode_left;
        logic k;
        joystick_left = 143;
        mode_left = 253;
        for (int p = 0; p < 4; p++)
        begin
            traffic = traffic_t'(p);
            if (p == 0)
            begin
                add_request(KIND_JOY, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
                add_request(KIND_JOY, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h00);
                add_request(KIND_JOY, 16'h8000, 16'h7FFF, 16'h0001, 8'hA5);
                add_request(KIND_MODE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
                add_request(KIND_MODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
                add_request(KIND_MODE, 16'h1234, 16'h8000, 16'h7FFF, 8'hAA);
                add_request(KIND_JOY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h5A);
                add_request(KIND_JOY, 16'h00FF, 16'hFF00, 16'h55AA, 8'h01);
                add_request(KIND_MODE, 16'h5555, 16'hAAAA, 16'h0F0F, 8'h55);
                add_request(KIND_MODE, 16'h0000, 16'hFFFF, 16'h0000, 8'h01);
                add_request(KIND_MODE, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h80);
                add_request(KIND_JOY, 16'h0001, 16'hFFFE, 16'h8001, 8'h7F);
                add_request(KIND_JOY, 16'hAA55, 16'h55AA, 16'h0000, 8'hFF);
                add_request(KIND_MODE, 16'h0000, 16'h0000, 16'h0000, 8'h7F);
            end
            // Mode requests outnumber joystick ones so the mode counter wraps.
            for (int n = 0; n < 99; n++)
            begin
                k = 1'($urandom_range(1));
                if (joystick_left == 0)
                    k = KIND_MODE;
                if (mode_left == 0)
                    k = KIND_JOY;
                if (k == KIND_JOY)
                    joystick_left--;
                else
                    mode_left--;
                add_request(k, pick_axis(), pick_axis(), pick_axis(), 8'($urandom));
            end
            // Sender holds off until every frame byte is back.
            while (pending_requests.size() != 0 || in_valid || octets_due.size() != 0)
                @(negedge clk);
            @(posedge clk);
        end
        repeat (24) @(negedge clk);
        if (error_count == 0 && octets_due.size() == 0)
            $display("tb_remote_frame_builder_crc16: clean");
        else
            $display("tb_remote_frame_builder_crc16: errors");
        $finish;
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #4_000_000;
        $display("tb_remote_frame_builder_crc16: errors");
        $finish;
    end

endmodule
